### rtl/core/spsa_pkg.sv
// ----------------------------------------------------------------------------
// SVG path segment assembler package
// Shared types, codes and sizes for the assembler's front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package spsa_pkg;

	// Points held in the polyline buffer before it is flushed.
	localparam int LINE_POINTS = 16;
	localparam int LINE_IDX_W  = $clog2(LINE_POINTS);
	localparam int LINE_CNT_W  = $clog2(LINE_POINTS + 1);

	// The emit index walks either the polyline buffer or four curve points.
	localparam int EMIT_IDX_W  = (LINE_IDX_W > 2) ? LINE_IDX_W : 2;
	localparam logic [EMIT_IDX_W-1:0] CURVE_LAST_IDX = EMIT_IDX_W'(3);

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Input actions.
	localparam logic [1:0] ACT_COORD = 2'd0;
	localparam logic [1:0] ACT_CMD   = 2'd1;
	localparam logic [1:0] ACT_BEGIN = 2'd2;

	// Command codes.
	localparam logic [2:0] CMD_MOVE_REL  = 3'd0;
	localparam logic [2:0] CMD_MOVE_ABS  = 3'd1;
	localparam logic [2:0] CMD_CURVE_REL = 3'd2;
	localparam logic [2:0] CMD_CURVE_ABS = 3'd3;
	localparam logic [2:0] CMD_CLOSE     = 3'd4;

	// Result kinds.
	localparam logic [1:0] KIND_LINE  = 2'd0;
	localparam logic [1:0] KIND_CURVE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_START_X = 1'b0;
	localparam logic CFG_START_Y = 1'b1;

	typedef struct packed {
		logic [1:0]         action;
		logic [2:0]         command_code;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} point_t;

	// Operation classes produced by the front.
	typedef enum logic [3:0] {
		OP_POINT,
		OP_MOVE_REL,
		OP_MOVE_ABS,
		OP_CURVE_REL,
		OP_CURVE_ABS,
		OP_CLOSE,
		OP_ERROR,
		OP_BEGIN,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t    op;
		point_t pt;
	} queue_entry_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LINE_RD,
		BK_LINE_WR,
		BK_CURVE,
		BK_END
	} back_state_t;

	// Signed 32-bit add that clamps to the nearest bound on overflow.
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sat_add = s[31:0];
		end
	endfunction

endpackage

`default_nettype wire

### rtl/core/spsa_front.sv
// ----------------------------------------------------------------------------
// SVG path assembler front
// Accepts input items and classifies each into one operation for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module spsa_front import spsa_pkg::*; (
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire in_item_t     in_item,
	output logic              push_valid,
	output queue_entry_t      push_entry,
	input  wire logic         queue_full
);

	assign in_ready   = !queue_full;
	assign push_valid = in_valid && !queue_full;

	always_comb begin
		push_entry.pt.x = in_item.coord_x;
		push_entry.pt.y = in_item.coord_y;
		case (in_item.action)
			ACT_COORD: push_entry.op = OP_POINT;
			ACT_BEGIN: push_entry.op = OP_BEGIN;
			ACT_CMD: begin
				case (in_item.command_code)
					CMD_MOVE_REL:  push_entry.op = OP_MOVE_REL;
					CMD_MOVE_ABS:  push_entry.op = OP_MOVE_ABS;
					CMD_CURVE_REL: push_entry.op = OP_CURVE_REL;
					CMD_CURVE_ABS: push_entry.op = OP_CURVE_ABS;
					CMD_CLOSE:     push_entry.op = OP_CLOSE;
					default:       push_entry.op = OP_ERROR;
				endcase
			end
			default: push_entry.op = OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/spsa_queue.sv
// ----------------------------------------------------------------------------
// SVG path assembler queue
// Short first-in first-out buffer of classified operations.
// ----------------------------------------------------------------------------
`default_nettype none

module spsa_queue import spsa_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	input  wire queue_entry_t  push_entry,
	output logic               full,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output queue_entry_t       pop_entry
);

	queue_entry_t             slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]   count_q;
	logic                     do_push;
	logic                     do_pop;

	assign full      = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_entry = slot_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

### rtl/core/spsa_back.sv
// ----------------------------------------------------------------------------
// SVG path assembler back
// Executes operations, keeps the path state and emits result items.
// ----------------------------------------------------------------------------
`default_nettype none

module spsa_back import spsa_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pop_valid,
	output logic               pop_ready,
	input  wire queue_entry_t  pop_entry,
	input  wire logic          cfg_valid,
	input  wire logic          cfg_index,
	input  wire logic [31:0]   cfg_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output out_item_t          out_item
);

	back_state_t             state_q, state_d;
	logic                    rel_q;
	logic [1:0]              phase_q;
	point_t                  cur_q;
	point_t                  start_q;
	logic [LINE_CNT_W-1:0]   count_q;
	logic [LINE_CNT_W-1:0]   flen_q;
	logic [EMIT_IDX_W-1:0]   idx_q;
	logic                    tail_end_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	point_t                  curve_q [3];
	point_t                  line_mem [LINE_POINTS];
	point_t                  rdata_q;
	point_t                  pend_q;

	logic                    slot_free;
	logic                    fire;
	logic                    line_last;
	logic                    out_load;
	out_item_t               out_d;
	point_t                  pt_abs;
	point_t                  curve_pt;

	assign slot_free = !out_valid_q || out_ready;
	assign fire      = pop_valid && pop_ready;
	assign line_last = (LINE_CNT_W'(idx_q[LINE_IDX_W-1:0]) + 1'b1) == flen_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Relative points are offset by the current point.
	always_comb begin
		if (rel_q) begin
			pt_abs.x = sat_add(pop_entry.pt.x, cur_q.x);
			pt_abs.y = sat_add(pop_entry.pt.y, cur_q.y);
		end else begin
			pt_abs = pop_entry.pt;
		end
	end

	assign curve_pt = (idx_q == CURVE_LAST_IDX) ? pend_q : curve_q[idx_q[1:0]];

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		out_load  = 1'b0;
		out_d     = '0;
		case (state_q)
			BK_IDLE: begin
				if (slot_free) begin
					pop_ready = 1'b1;
					if (pop_valid) begin
						case (pop_entry.op)
							OP_POINT: begin
								if (phase_q == 2'd0
									&& count_q == LINE_CNT_W'(LINE_POINTS - 1)) begin
									state_d = BK_LINE_RD;
								end else if (phase_q == 2'd3) begin
									state_d = BK_CURVE;
								end
							end
							OP_CURVE_REL, OP_CURVE_ABS: begin
								if (count_q != '0) begin
									state_d = BK_LINE_RD;
								end
							end
							OP_CLOSE: begin
								state_d = (count_q != '0) ? BK_LINE_RD : BK_END;
							end
							OP_ERROR: begin
								out_load      = 1'b1;
								out_d.kind    = KIND_ERROR;
								out_d.last    = 1'b1;
							end
							default: ;
						endcase
					end
				end
			end
			BK_LINE_RD: state_d = BK_LINE_WR;
			BK_LINE_WR: begin
				if (slot_free) begin
					out_load      = 1'b1;
					out_d.kind    = KIND_LINE;
					out_d.point_x = rdata_q.x;
					out_d.point_y = rdata_q.y;
					out_d.last    = line_last && !tail_end_q;
					if (line_last) begin
						state_d = tail_end_q ? BK_END : BK_IDLE;
					end else begin
						state_d = BK_LINE_RD;
					end
				end
			end
			BK_CURVE: begin
				if (slot_free) begin
					out_load      = 1'b1;
					out_d.kind    = KIND_CURVE;
					out_d.point_x = curve_pt.x;
					out_d.point_y = curve_pt.y;
					out_d.last    = (idx_q == CURVE_LAST_IDX);
					if (idx_q == CURVE_LAST_IDX) begin
						state_d = BK_IDLE;
					end
				end
			end
			BK_END: begin
				if (slot_free) begin
					out_load      = 1'b1;
					out_d.kind    = KIND_END;
					out_d.point_x = cur_q.x;
					out_d.point_y = cur_q.y;
					out_d.last    = 1'b1;
					state_d       = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q       <= 1'b0;
			phase_q     <= 2'd0;
			cur_q       <= '0;
			start_q     <= '0;
			count_q     <= '0;
			flen_q      <= '0;
			idx_q       <= '0;
			tail_end_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_START_X) begin
					start_q.x <= cfg_data;
				end else begin
					start_q.y <= cfg_data;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				case (pop_entry.op)
					OP_POINT: begin
						if (phase_q == 2'd0) begin
							cur_q <= pt_abs;
							if (count_q == LINE_CNT_W'(LINE_POINTS - 1)) begin
								count_q    <= '0;
								flen_q     <= LINE_CNT_W'(LINE_POINTS);
								idx_q      <= '0;
								tail_end_q <= 1'b0;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end else if (phase_q == 2'd3) begin
							phase_q <= 2'd1;
							idx_q   <= '0;
						end else begin
							phase_q <= phase_q + 1'b1;
						end
					end
					OP_MOVE_REL: begin
						rel_q   <= 1'b1;
						phase_q <= 2'd0;
					end
					OP_MOVE_ABS: begin
						rel_q   <= 1'b0;
						phase_q <= 2'd0;
					end
					OP_CURVE_REL, OP_CURVE_ABS: begin
						rel_q      <= (pop_entry.op == OP_CURVE_REL);
						phase_q    <= 2'd1;
						flen_q     <= count_q;
						count_q    <= '0;
						idx_q      <= '0;
						tail_end_q <= 1'b0;
					end
					OP_CLOSE: begin
						rel_q      <= 1'b0;
						phase_q    <= 2'd0;
						flen_q     <= count_q;
						count_q    <= '0;
						idx_q      <= '0;
						tail_end_q <= 1'b1;
					end
					OP_BEGIN: begin
						cur_q   <= start_q;
						rel_q   <= 1'b0;
						phase_q <= 2'd0;
						count_q <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == BK_LINE_WR && slot_free && !line_last) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == BK_CURVE && slot_free) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == CURVE_LAST_IDX) begin
					cur_q <= pend_q;
				end
			end
		end
	end

	// Point storage: curve points, polyline buffer and the output payload.
	always_ff @(posedge clk) begin
		if (fire && pop_entry.op == OP_POINT) begin
			if (phase_q == 2'd0) begin
				line_mem[count_q[LINE_IDX_W-1:0]] <= pt_abs;
			end else if (phase_q == 2'd3) begin
				pend_q <= pt_abs;
			end else begin
				curve_q[phase_q] <= pt_abs;
			end
		end
		if (fire && (pop_entry.op == OP_CURVE_REL || pop_entry.op == OP_CURVE_ABS)) begin
			curve_q[0] <= cur_q;
		end
		if (state_q == BK_CURVE && slot_free && idx_q == CURVE_LAST_IDX) begin
			curve_q[0] <= pend_q;
		end
		rdata_q <= line_mem[idx_q[LINE_IDX_W-1:0]];
		if (out_load) begin
			out_q <= out_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/svg_path_segment_assembler_unit.sv
// ----------------------------------------------------------------------------
// SVG path segment assembler
// Turns tokenized SVG path items into polyline, curve, path end and error
// results with absolute Q16.16 coordinates.
// ----------------------------------------------------------------------------
// Usage. Input items arrive on in_valid/in_ready with the in_item payload;
// result items leave on out_valid/out_ready with out_item, and out_item.last
// marks the final result caused by one input item. Registers start_x and
// start_y are written through cfg_valid/cfg_ready (always ready) with
// cfg_index and cfg_data, by the user only while the block is idle; the block
// itself does not enforce this. The front classifies an item in the cycle it
// is accepted and places it in a two-entry queue. The back, the rate limit,
// takes one operation per cycle from the queue while in BK_IDLE with a free
// output register, and takes no new one until a flush, cubic or path end is
// emitted. An error result passes through the queue and the output register;
// a path end or a cubic's first point also through BK_END or BK_CURVE, and a
// polyline flush reads the buffer one entry at a time through BK_LINE_RD and
// BK_LINE_WR per point; a cubic streams its four points from BK_CURVE.
// Reset clears the path state, the buffer count, the queue and start_x/y to
// zero. When the receiver stalls, the result waits in the output register,
// the back halts and the queue fills, after which in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module svg_path_segment_assembler_unit import spsa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_item,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic          push_valid;
	queue_entry_t  push_entry;
	logic          queue_full;
	logic          pop_valid;
	logic          pop_ready;
	queue_entry_t  pop_entry;

	// Register writes are always taken at once.
	assign cfg_ready = 1'b1;

	// The front decodes the action and command into one operation class.
	spsa_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.queue_full (queue_full)
	);

	// The queue lets the front keep accepting while the back emits results.
	spsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// The back holds the path state and sequences all result items.
	spsa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

### rtl/core/spsa_checker.sv
// ----------------------------------------------------------------------------
// SVG path assembler checker
// Port-level properties of the assembler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spsa_checker import spsa_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire out_item_t   out_item,
	input wire logic        cfg_ready
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// An error result carries the origin and ends its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == KIND_ERROR
		|-> out_item.point_x == 0 && out_item.point_y == 0 && out_item.last)
		else $error("malformed error result");

	// A path end is always the final result of its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == KIND_END |-> out_item.last)
		else $error("path end without last");

	// Register writes never wait.
	assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind svg_path_segment_assembler_unit spsa_checker u_spsa_checker (.*);

`default_nettype wire

### test/tb_svg_path_segment_assembler_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SVG path segment assembler testbench
// Drives path items into the assembler, predicts every result in order and
// compares each result item with the oldest prediction, with random stalls.
// ----------------------------------------------------------------------------

module tb_svg_path_segment_assembler_unit;
	import spsa_pkg::*;

	// Action code that the block ignores.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// Cubic phases: collecting polyline points, first handle, end point.
	localparam logic [1:0] PH_LINE   = 2'd0;
	localparam logic [1:0] PH_HANDLE = 2'd1;
	localparam logic [1:0] PH_END_PT = 2'd3;

	// Cycles to let pass once the last result has come, so that items
	// without results (moves, begin-path, buffered points) leave the block.
	localparam int SETTLE_CYCLES = 16;

	// Cycles without any accepted item before the run is declared hung. The
	// longest quiet stretch is a receiver stall plus the settle pause, so this
	// leaves a wide margin.
	localparam int STALL_LIMIT = 500;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam longint WIDE_MAX = 64'sd2147483647;
	localparam longint WIDE_MIN = -64'sd2147483648;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_START_X;
	logic [31:0] cfg_data = '0;

	// Path state of the predictor, kept in step with the block.
	logic signed [31:0] start_x_reg = '0;
	logic signed [31:0] start_y_reg = '0;
	logic               rel_mode = 1'b0;
	logic [1:0]         phase = PH_LINE;
	point_t             cur_pt = '0;
	point_t             curve_pts [3];
	point_t             line_buf [LINE_POINTS];
	int                 line_cnt = 0;

	// Results caused by the item being predicted, and all results still owed.
	out_item_t step_results [$];
	out_item_t pending_results [$];

	int mismatches = 0;
	int tokens_sent = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;

	svg_path_segment_assembler_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Relative offsets clamp to the signed 32-bit range instead of wrapping.
	function automatic logic signed [31:0] clamp_add(input logic signed [31:0] a,
		input logic signed [31:0] b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > WIDE_MAX) begin
			return Q_MAX;
		end
		if (s < WIDE_MIN) begin
			return Q_MIN;
		end
		return s[31:0];
	endfunction

	task automatic push_result(input logic [1:0] kind, input point_t p);
		out_item_t r;
		r.kind    = kind;
		r.point_x = p.x;
		r.point_y = p.y;
		r.last    = 1'b0;
		step_results.push_back(r);
	endtask

	// Every buffered polyline point comes out in the order it was stored.
	task automatic flush_line();
		for (int i = 0; i < line_cnt; i++) begin
			push_result(KIND_LINE, line_buf[i]);
		end
		line_cnt = 0;
	endtask

	// Updates the path state for one accepted item and queues its results.
	task automatic assemble_token(input in_item_t tok);
		point_t    p;
		out_item_t r;
		step_results.delete();
		case (tok.action)
		ACT_COORD: begin
			p.x = tok.coord_x;
			p.y = tok.coord_y;
			if (rel_mode) begin
				p.x = clamp_add(tok.coord_x, cur_pt.x);
				p.y = clamp_add(tok.coord_y, cur_pt.y);
			end
			if (phase == PH_LINE) begin
				cur_pt = p;
				line_buf[line_cnt] = p;
				line_cnt++;
				// The buffer flushes the moment it is exactly full.
				if (line_cnt == LINE_POINTS) begin
					flush_line();
				end
			end else if (phase != PH_END_PT) begin
				// Control handles are stored but leave the current point alone.
				curve_pts[phase] = p;
				phase++;
			end else begin
				for (int i = 0; i < 3; i++) begin
					push_result(KIND_CURVE, curve_pts[i]);
				end
				push_result(KIND_CURVE, p);
				cur_pt = p;
				curve_pts[0] = p;
				phase = PH_HANDLE;
			end
		end
		ACT_CMD: begin
			case (tok.command_code)
			CMD_MOVE_REL: begin
				rel_mode = 1'b1;
				phase = PH_LINE;
			end
			CMD_MOVE_ABS: begin
				rel_mode = 1'b0;
				phase = PH_LINE;
			end
			CMD_CURVE_REL, CMD_CURVE_ABS: begin
				// A curve always starts at the current point.
				flush_line();
				rel_mode = (tok.command_code == CMD_CURVE_REL);
				curve_pts[0] = cur_pt;
				phase = PH_HANDLE;
			end
			CMD_CLOSE: begin
				flush_line();
				push_result(KIND_END, cur_pt);
				rel_mode = 1'b0;
				phase = PH_LINE;
			end
			default: begin
				// Unknown command: one error result, state untouched.
				push_result(KIND_ERROR, '0);
			end
			endcase
		end
		ACT_BEGIN: begin
			cur_pt.x = start_x_reg;
			cur_pt.y = start_y_reg;
			rel_mode = 1'b0;
			phase = PH_LINE;
			line_cnt = 0;
		end
		default: ;
		endcase
		if (step_results.size() != 0) begin
			r = step_results.pop_back();
			r.last = 1'b1;
			step_results.push_back(r);
		end
		foreach (step_results[i]) begin
			pending_results.push_back(step_results[i]);
		end
	endtask

	// ------------------------------------------------------------------
	// Item builders
	// ------------------------------------------------------------------

	// Mostly small coordinates so relative paths wander, with the bounds
	// and full-range values mixed in to hit saturation.
	function automatic logic signed [31:0] rand_q16();
		case ($urandom_range(0, 9))
		0: return Q_MIN;
		1: return Q_MAX;
		2, 3, 4: return $urandom;
		default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
		endcase
	endfunction

	// Fields that an action ignores carry random bits.
	function automatic in_item_t coord_tok(input logic signed [31:0] x,
		input logic signed [31:0] y);
		in_item_t t;
		t.action       = ACT_COORD;
		t.command_code = 3'($urandom);
		t.coord_x      = x;
		t.coord_y      = y;
		return t;
	endfunction

	function automatic in_item_t cmd_tok(input logic [2:0] code);
		in_item_t t;
		t.action       = ACT_CMD;
		t.command_code = code;
		t.coord_x      = $urandom;
		t.coord_y      = $urandom;
		return t;
	endfunction

	function automatic in_item_t begin_tok();
		in_item_t t;
		t = cmd_tok(3'($urandom));
		t.action = ACT_BEGIN;
		return t;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Presents one item and holds it until it is accepted. Valid stays high
	// into the next item unless a random gap lowers it first.
	task automatic send_token(input in_item_t tok);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= tok;
		do @(posedge clk); while (in_ready !== 1'b1);
		assemble_token(tok);
		if (tok.action != ACT_UNUSED) begin
			tokens_sent++;
		end
	endtask

	// Stops sending and waits until every owed result has come, then lets
	// items without results work their way out of the block.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both start registers back to back; only call while idle.
	task automatic write_start(input logic signed [31:0] x, input logic signed [31:0] y);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_START_X;
		cfg_data  <= x;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		start_x_reg = x;
		cfg_index <= CFG_START_Y;
		cfg_data  <= y;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		start_y_reg = y;
		cfg_valid <= 1'b0;
	endtask

	// The receiver stalls in random bursts, except in the last part.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Result checker and watchdog
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, kind %0d x %h y %h last %b", $time,
					out_item.kind, out_item.point_x, out_item.point_y, out_item.last);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (want !== out_item) begin
					$display("%0t: expected kind %0d x %h y %h last %b, actual kind %0d x %h y %h last %b",
						$time, want.kind, want.point_x, want.point_y, want.last,
						out_item.kind, out_item.point_x, out_item.point_y, out_item.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every command, the coordinate bounds, saturation in both directions,
	// unknown codes and the ignored action.
	task automatic test_commands();
		write_start(32'sh0001_8000, -32'sh0002_0000);
		send_token(begin_tok());
		send_token(cmd_tok(CMD_CLOSE));
		send_token(cmd_tok(CMD_MOVE_ABS));
		send_token(coord_tok(32'sh7FFF_0000, 32'sh8001_0000));
		send_token(cmd_tok(CMD_MOVE_REL));
		// Positive overflow on x, negative on y.
		send_token(coord_tok(Q_MAX, Q_MIN));
		send_token(coord_tok(Q_MIN, Q_MAX));
		// The curve flushes the three buffered points first.
		send_token(cmd_tok(CMD_CURVE_REL));
		send_token(coord_tok(32'sd2, 32'sd2));
		send_token(coord_tok(Q_MIN, Q_MIN));
		send_token(coord_tok(32'sd0, 32'sd1));
		send_token(cmd_tok(CMD_CURVE_ABS));
		send_token(coord_tok(Q_MIN, Q_MAX));
		send_token(coord_tok(Q_MAX, Q_MIN));
		send_token(coord_tok(32'sd0, 32'sd0));
		send_token(cmd_tok(CMD_CLOSE));
		send_token(cmd_tok(3'd5));
		send_token(cmd_tok(3'd6));
		send_token(cmd_tok(3'd7));
		send_token(coord_tok(32'sd7, 32'sd9) | {ACT_UNUSED, 67'd0});
		send_token(cmd_tok(CMD_MOVE_ABS));
		send_token(coord_tok(32'sh0001_0000, 32'sh0002_0000));
		send_token(cmd_tok(CMD_CLOSE));
	endtask

	// Sixteen points fill the buffer exactly and flush it on the spot.
	task automatic test_full_buffer();
		send_token(begin_tok());
		send_token(cmd_tok(CMD_MOVE_REL));
		repeat (LINE_POINTS + 1) begin
			send_token(coord_tok($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000,
				$signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000));
		end
		send_token(cmd_tok(CMD_CLOSE));
	endtask

	// The start registers at their bounds, seen through begin-path.
	task automatic test_start_extremes();
		drain_results();
		write_start(Q_MIN, Q_MAX);
		send_token(begin_tok());
		send_token(cmd_tok(CMD_CLOSE));
		drain_results();
		write_start(Q_MAX, Q_MIN);
		send_token(begin_tok());
		send_token(cmd_tok(CMD_MOVE_REL));
		send_token(coord_tok(32'sd1, -32'sd1));
		send_token(coord_tok(Q_MIN, Q_MAX));
		send_token(cmd_tok(CMD_CLOSE));
	endtask

	// One well-formed path with random content; sometimes a curve is cut
	// short or the close is left out.
	task automatic random_path();
		int n_pts;
		int n_curves;
		if ($urandom_range(0, 9) < 7) begin
			send_token(begin_tok());
		end
		send_token(cmd_tok($urandom_range(0, 1) ? CMD_MOVE_REL : CMD_MOVE_ABS));
		n_pts = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
		repeat (n_pts) send_token(coord_tok(rand_q16(), rand_q16()));
		if ($urandom_range(0, 1)) begin
			send_token(cmd_tok($urandom_range(0, 1) ? CMD_CURVE_REL : CMD_CURVE_ABS));
			n_curves = 3 * $urandom_range(1, 3);
			if ($urandom_range(0, 3) == 0) begin
				n_curves += $urandom_range(1, 2);
			end
			repeat (n_curves) send_token(coord_tok(rand_q16(), rand_q16()));
			if ($urandom_range(0, 3) == 0) begin
				send_token(cmd_tok(CMD_MOVE_ABS));
				repeat ($urandom_range(1, 4)) send_token(coord_tok(rand_q16(), rand_q16()));
			end
		end
		if ($urandom_range(0, 9) < 8) begin
			send_token(cmd_tok(CMD_CLOSE));
		end
	endtask

	// Random phases with new start values between them. About one pick in ten
	// is a noise item, not a path; now and then the sender waits for all results.
	task automatic test_random();
		int first;
		in_item_t t;
		for (int ph = 0; ph < 3; ph++) begin
			drain_results();
			if (ph == 2) begin
				quiet = 1'b1;
				write_start('0, '0);
			end else begin
				write_start(rand_q16(), rand_q16());
			end
			first = tokens_sent;
			while (tokens_sent - first < 30) begin
				if ($urandom_range(0, 9) == 0) begin
					t = coord_tok(rand_q16(), rand_q16());
					t.action = 2'($urandom_range(0, 3));
					t.command_code = 3'($urandom_range(0, 7));
					send_token(t);
				end else begin
					random_path();
				end
				if ($urandom_range(0, 7) == 0) begin
					drain_results();
				end
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_commands();
		test_full_buffer();
		test_start_extremes();
		test_random();

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

### svg_path_segment_assembler_unit.f
rtl/core/spsa_pkg.sv
rtl/core/spsa_front.sv
rtl/core/spsa_queue.sv
rtl/core/spsa_back.sv
rtl/core/svg_path_segment_assembler_unit.sv
rtl/core/spsa_checker.sv
test/tb_svg_path_segment_assembler_unit.sv
